// ===== rtl/core/cpff_pkg.sv =====
// Package: shared types, constants and helper functions for the CSI peer filter framer.
package cpff_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int PEER_SLOTS      = 4;
    localparam int PEER_REGS       = 4;
    localparam int HDR_BYTES       = 20;
    localparam int MAX_PAYLOAD     = MAX_FRAME_BYTES - HDR_BYTES;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [31:0] FRAME_MAGIC = 32'hC511_0001;
    localparam logic [7:0]  ANT_COUNT   = 8'd1;

    localparam logic [12:0] FREQ_24_BASE = 13'd2407;  // 2412 - 5
    localparam logic [12:0] FREQ_CH14    = 13'd2484;
    localparam logic [12:0] FREQ_5G_BASE = 13'd5000;
    localparam logic [7:0]  CH_24_LAST   = 8'd13;
    localparam logic [7:0]  CH_14        = 8'd14;
    localparam logic [7:0]  CH_5G_FIRST  = 8'd36;
    localparam logic [7:0]  CH_5G_LAST   = 8'd177;

    typedef enum logic [2:0] {
        REG_PEER_A,
        REG_PEER_B,
        REG_PEER_C,
        REG_PEER_D,
        REG_NODE_IDS,
        REG_PEER_COUNT,
        REG_FALLBACK_MAC,
        REG_FALLBACK_EN
    } cpff_reg_t;

    typedef struct packed {
        logic [PEER_REGS-1:0][47:0] peer_addr;
        logic [39:0]                node_ids;
        logic [2:0]                 peer_count;
        logic [47:0]                fallback_mac;
        logic                       fallback_en;
    } cpff_cfg_t;

    // One queue entry: a header with its optional first payload word, or a lone payload word.
    typedef struct packed {
        logic        is_hdr;
        logic        has_data;
        logic [7:0]  data;
        logic        data_eof;
        logic [7:0]  peer_id;
        logic [7:0]  node_id;
        logic [14:0] subc;
        logic [12:0] freq;
        logic [31:0] seq;
        logic [7:0]  rssi;
        logic [7:0]  noise;
    } cpff_cmd_t;

    function automatic logic [12:0] chan_to_mhz(input logic [7:0] ch);
        logic [12:0] ch5;
        ch5 = 13'({ch, 2'b00}) + 13'(ch);
        if (ch != 8'd0 && ch <= CH_24_LAST)
            chan_to_mhz = FREQ_24_BASE + ch5;
        else if (ch == CH_14)
            chan_to_mhz = FREQ_CH14;
        else if (ch >= CH_5G_FIRST && ch <= CH_5G_LAST)
            chan_to_mhz = FREQ_5G_BASE + ch5;
        else
            chan_to_mhz = 13'd0;
    endfunction

    // Frame word at position idx; position HDR_BYTES is the carried payload word.
    function automatic logic [7:0] frame_byte(input cpff_cmd_t c, input logic [4:0] idx);
        logic [31:0] freq32;
        freq32 = 32'(c.freq);
        case (idx)
            5'd0:    frame_byte = FRAME_MAGIC[7:0];
            5'd1:    frame_byte = FRAME_MAGIC[15:8];
            5'd2:    frame_byte = FRAME_MAGIC[23:16];
            5'd3:    frame_byte = FRAME_MAGIC[31:24];
            5'd4:    frame_byte = c.node_id;
            5'd5:    frame_byte = ANT_COUNT;
            5'd6:    frame_byte = c.subc[7:0];
            5'd7:    frame_byte = {1'b0, c.subc[14:8]};
            5'd8:    frame_byte = freq32[7:0];
            5'd9:    frame_byte = freq32[15:8];
            5'd10:   frame_byte = freq32[23:16];
            5'd11:   frame_byte = freq32[31:24];
            5'd12:   frame_byte = c.seq[7:0];
            5'd13:   frame_byte = c.seq[15:8];
            5'd14:   frame_byte = c.seq[23:16];
            5'd15:   frame_byte = c.seq[31:24];
            5'd16:   frame_byte = c.rssi;
            5'd17:   frame_byte = c.noise;
            5'd20:   frame_byte = c.data;
            default: frame_byte = 8'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/cpff_regs.sv =====
// Configuration register file: peer table, node ids and filter controls.
module cpff_regs
    import cpff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output cpff_cfg_t   cfg
);

    cpff_cfg_t cfg_reg, cfg_next;
    cpff_reg_t idx;

    assign cfg_ready = 1'b1;
    assign idx       = cpff_reg_t'(cfg_index);
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (idx) inside
                REG_PEER_A, REG_PEER_B, REG_PEER_C, REG_PEER_D: begin
                    cfg_next.peer_addr[cfg_index[1:0]] = cfg_data;
                end
                REG_NODE_IDS:     cfg_next.node_ids     = cfg_data[39:0];
                REG_PEER_COUNT:   cfg_next.peer_count   = cfg_data[2:0];
                REG_FALLBACK_MAC: cfg_next.fallback_mac = cfg_data;
                REG_FALLBACK_EN:  cfg_next.fallback_en  = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/cpff_front.sv =====
// Front end: source filtering, frame bound check and record tracking; emits queue commands.
module cpff_front
    import cpff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cpff_cfg_t   cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_iq_byte,
    input  logic        s_first_of_record,
    input  logic [47:0] s_source_mac,
    input  logic [7:0]  s_channel_number,
    input  logic signed [7:0] s_rssi,
    input  logic signed [7:0] s_noise_floor,
    input  logic [15:0] s_payload_length,
    input  logic        q_full,
    output logic        push,
    output cpff_cmd_t   push_cmd
);

    logic [15:0] rem_reg, rem_next;
    logic        acc_reg, acc_next;
    logic [7:0]  pid_reg, pid_next;
    logic [31:0] seq_reg, seq_next;

    logic        take;
    logic [2:0]  active;
    logic        hit;
    logic [7:0]  hit_id;
    logic        pass;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign active  = (cfg.peer_count > 3'(PEER_SLOTS)) ? 3'(PEER_SLOTS) : cfg.peer_count;

    always_comb begin
        hit    = 1'b0;
        hit_id = 8'd0;
        for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
            if (3'(i) < active && cfg.peer_addr[i] == s_source_mac) begin
                hit    = 1'b1;
                hit_id = cfg.node_ids[8*(i+1) +: 8];
            end
        end
    end

    always_comb begin
        if (active != 3'd0)
            pass = hit;
        else if (cfg.fallback_en)
            pass = (s_source_mac == cfg.fallback_mac);
        else
            pass = 1'b1;
        if ({1'b0, s_payload_length} > 17'(MAX_PAYLOAD))
            pass = 1'b0;
    end

    always_comb begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        pid_next = pid_reg;
        seq_next = seq_reg;
        push     = 1'b0;
        push_cmd = '0;
        if (take) begin
            if (s_first_of_record) begin
                rem_next = (s_payload_length != 16'd0) ? s_payload_length - 16'd1 : 16'd0;
                acc_next = pass && (s_payload_length > 16'd1);
                pid_next = pass ? hit_id : 8'd0;
                if (pass) begin
                    push              = 1'b1;
                    seq_next          = seq_reg + 32'd1;
                    push_cmd.is_hdr   = 1'b1;
                    push_cmd.has_data = (s_payload_length != 16'd0);
                    push_cmd.data     = s_iq_byte;
                    push_cmd.data_eof = (s_payload_length == 16'd1);
                    push_cmd.peer_id  = hit_id;
                    push_cmd.node_id  = cfg.node_ids[7:0];
                    push_cmd.subc     = s_payload_length[15:1];
                    push_cmd.freq     = chan_to_mhz(s_channel_number);
                    push_cmd.seq      = seq_reg;
                    push_cmd.rssi     = s_rssi;
                    push_cmd.noise    = s_noise_floor;
                end
            end else if (rem_reg != 16'd0) begin
                rem_next = rem_reg - 16'd1;
                if (acc_reg) begin
                    push              = 1'b1;
                    push_cmd.has_data = 1'b1;
                    push_cmd.data     = s_iq_byte;
                    push_cmd.data_eof = (rem_reg == 16'd1);
                    push_cmd.peer_id  = pid_reg;
                    if (rem_reg == 16'd1)
                        acc_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            acc_reg <= 1'b0;
            pid_reg <= '0;
            seq_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            pid_reg <= pid_next;
            seq_reg <= seq_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_acc_needs_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg == 16'd0) |-> !acc_reg)
        else $error("record marked accepted with no payload left");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_cmd.is_hdr) |=> (seq_reg == $past(seq_reg) + 32'd1))
        else $error("sequence did not advance on header");

    a_push_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && !q_full))
        else $error("queue push without accepted word");
`endif

endmodule

// ===== rtl/core/cpff_fifo.sv =====
// Command queue between front end and frame serializer.
module cpff_fifo
    import cpff_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cpff_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output cpff_cmd_t head
);

    cpff_cmd_t        mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_reg, wr_next;
    logic [QAW-1:0]   rd_reg, rd_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCW'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? QAW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? QAW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCW'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/cpff_back.sv =====
// Back end: serializes header and payload words into the registered output stage.
module cpff_back
    import cpff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  cpff_cmd_t   head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_end_of_frame,
    output logic [7:0]  m_source_peer_id
);

    cpff_cmd_t   cur_reg, cur_next;
    logic        busy_reg, busy_next;
    logic [4:0]  idx_reg, idx_next;
    logic        vld_reg, vld_next;
    logic [7:0]  byte_reg, byte_next;
    logic        eof_reg, eof_next;
    logic [7:0]  peer_reg, peer_next;

    logic        load_ok;
    logic        last;

    assign load_ok = !vld_reg || m_ready;
    assign last    = (idx_reg == 5'(HDR_BYTES - 1) && !cur_reg.has_data) ||
                     (idx_reg == 5'(HDR_BYTES));

    always_comb begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        vld_next  = vld_reg && !m_ready;
        byte_next = byte_reg;
        eof_next  = eof_reg;
        peer_next = peer_reg;
        pop       = 1'b0;
        if (load_ok) begin
            if (busy_reg) begin
                vld_next  = 1'b1;
                byte_next = frame_byte(cur_reg, idx_reg);
                eof_next  = (idx_reg == 5'(HDR_BYTES)) ? cur_reg.data_eof : last;
                peer_next = cur_reg.peer_id;
                if (last)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg + 5'd1;
            end else if (head_valid) begin
                pop       = 1'b1;
                vld_next  = 1'b1;
                peer_next = head.peer_id;
                if (head.is_hdr) begin
                    byte_next = frame_byte(head, 5'd0);
                    eof_next  = 1'b0;
                    cur_next  = head;
                    busy_next = 1'b1;
                    idx_next  = 5'd1;
                end else begin
                    byte_next = head.data;
                    eof_next  = head.data_eof;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        eof_reg  <= eof_next;
        peer_reg <= peer_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            vld_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            vld_reg  <= vld_next;
        end
    end

    assign m_valid          = vld_reg;
    assign m_out_byte       = byte_reg;
    assign m_end_of_frame   = eof_reg;
    assign m_source_peer_id = peer_reg;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg >= 5'd1 && idx_reg <= 5'(HDR_BYTES)))
        else $error("header index out of range");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !pop)
        else $error("queue popped while header in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte) &&
                                   $stable(m_end_of_frame) && $stable(m_source_peer_id)))
        else $error("output word changed while stalled");
`endif

endmodule

// ===== rtl/core/csi_peer_filter_framer.sv =====
// Top level: CSI record peer filter and frame builder.
// Takes one I/Q word per cycle on s_* while s_ready is high; the first word of each record
// carries the header fields. Records from sources outside the active peer table (with an empty
// table, only the fallback MAC passes if enabled, else all sources pass) or over the frame bound
// are dropped. An accepted record's first word expands into 20 header words plus its first
// payload word (none for a header-only record), serialized one per cycle by the back end
// while m_ready is high. A four-entry command queue lets the input keep flowing while the
// header goes out; once full, s_ready drops until the serializer catches up.
// Configuration writes (cfg_*) are always ready and take effect on the next cycle.
module csi_peer_filter_framer
    import cpff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_iq_byte,
    input  logic        s_first_of_record,
    input  logic [47:0] s_source_mac,
    input  logic [7:0]  s_channel_number,
    input  logic signed [7:0] s_rssi,
    input  logic signed [7:0] s_noise_floor,
    input  logic [15:0] s_payload_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_end_of_frame,
    output logic [7:0]  m_source_peer_id
);

    cpff_cfg_t cfg;
    logic      q_full;
    logic      push;
    cpff_cmd_t push_cmd;
    logic      pop;
    logic      head_valid;
    cpff_cmd_t head;

    cpff_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpff_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_iq_byte         (s_iq_byte),
        .s_first_of_record (s_first_of_record),
        .s_source_mac      (s_source_mac),
        .s_channel_number  (s_channel_number),
        .s_rssi            (s_rssi),
        .s_noise_floor     (s_noise_floor),
        .s_payload_length  (s_payload_length),
        .q_full            (q_full),
        .push              (push),
        .push_cmd          (push_cmd)
    );

    cpff_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cpff_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_end_of_frame   (m_end_of_frame),
        .m_source_peer_id (m_source_peer_id)
    );

endmodule
